FILE: rtl/dda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_pkg - shared types and constants of the DDA line pixel generator
// Register indexes, input kinds and the divider status bundle.
// ----------------------------------------------------------------------------

package dda_pkg;

    // configuration port
    localparam int SCREEN_BITS    = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // input beat kinds (tuser)
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // status of the shared divider
    typedef struct packed {
        logic busy;   // iterations in progress
        logic done;   // quotient valid, one-cycle pulse
    } dda_div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/dda_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_div - shared restoring divider
// Computes (num << (Q_BITS-1)) / den for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------

module dda_div #(
    parameter int NUM_BITS = 13,
    parameter int Q_BITS   = 17
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [NUM_BITS-1:0]           num,
    input  wire [NUM_BITS-1:0]           den,
    output dda_pkg::dda_div_stat_t       stat,
    output logic [Q_BITS-1:0]            quo
);

    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic [NUM_BITS:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0] den_reg, den_next;
    logic [Q_BITS-1:0]   quo_reg, quo_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                done_reg, done_next;

    logic                ge;
    logic [NUM_BITS:0]   diff;
    logic [NUM_BITS:0]   kept;

    // rem < den after each subtract, so the shifted value fits NUM_BITS+1
    assign ge   = (rem_reg >= {1'b0, den_reg});
    assign diff = rem_reg - {1'b0, den_reg};
    assign kept = ge ? diff : rem_reg;

    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = {1'b0, num};
            den_next   = den;
            quo_next   = '0;
            count_next = CNT_BITS'(Q_BITS);
        end
        else if (count_reg != '0)
        begin
            rem_next   = {kept[NUM_BITS-1:0], 1'b0};
            quo_next   = {quo_reg[Q_BITS-2:0], ge};
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = (count_reg != '0);
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/dda_line_pixel_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_pixel_generator - DDA line walker
// Start beats load a line and compute fixed-point increments; step beats on an
// active line emit one rounded pixel each with visibility and last flags.
// ----------------------------------------------------------------------------
// Step beat: pixel valid the next cycle after acceptance; one step per
//   cycle while the output is taken.
// Start beat: input ready again only once the span state and the shared
//   bit-serial divider have finished dx, then dy.
// Reset (rst_n, async low): no line active, screen size 0, output empty.

module dda_line_pixel_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // from bit 0: start_x, start_y, end_x, end_y, line_color, zero pad
    input  wire [((4*COORD_BITS+32+7)/8)*8-1:0]  s_tdata,
    // bit 0: kind
    input  wire                                  s_tuser,
    // pixel stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // from bit 0: pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
    // bit 0: visible
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    // configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [dda_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [dda_pkg::SCREEN_BITS-1:0]       cfg_data
);

    localparam int CB       = COORD_BITS;
    localparam int FB       = FRAC_BITS;
    localparam int D_BITS   = CB + 1;          // endpoint difference / span
    localparam int POS_BITS = CB + 1 + FB;     // position accumulator
    localparam int STEP_BITS = FB + 2;         // signed increment
    localparam int Q_BITS   = FB + 1;          // increment magnitude
    localparam int SB       = dda_pkg::SCREEN_BITS;
    localparam int VIS_BITS = (CB > SB) ? CB : SB;
    localparam int M_DATA_BITS = ((2*CB+32+7)/8)*8;

    localparam logic [POS_BITS-1:0] HALF = POS_BITS'(1) << (FB - 1);

    // sequencer
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SPAN  = 2'd1;
    localparam logic [1:0] ST_DIV_X = 2'd2;
    localparam logic [1:0] ST_DIV_Y = 2'd3;

    logic [1:0]            state_reg, state_next;

    // line state
    logic [D_BITS-1:0]     dx_reg, dx_next;
    logic [D_BITS-1:0]     dy_reg, dy_next;
    logic [D_BITS-1:0]     ay_reg, ay_next;
    logic [D_BITS-1:0]     span_reg, span_next;
    logic                  span_zero_reg, span_zero_next;
    logic [POS_BITS-1:0]   pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0]   pos_y_reg, pos_y_next;
    logic [STEP_BITS-1:0]  step_x_reg, step_x_next;
    logic [STEP_BITS-1:0]  step_y_reg, step_y_next;
    logic [D_BITS-1:0]     pixels_left_reg, pixels_left_next;
    logic [31:0]           color_reg, color_next;
    logic                  line_active_reg, line_active_next;

    // configuration
    logic [SB-1:0]         width_reg, width_next;
    logic [SB-1:0]         height_reg, height_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [CB-1:0]         out_x_reg, out_x_next;
    logic [CB-1:0]         out_y_reg, out_y_next;
    logic [31:0]           out_color_reg, out_color_next;
    logic                  out_vis_reg, out_vis_next;
    logic                  out_last_reg, out_last_next;

    // input fields
    logic [CB-1:0]         in_start_x, in_start_y, in_end_x, in_end_y;
    logic [31:0]           in_color;
    logic                  in_accept;

    assign in_start_x = s_tdata[CB-1:0];
    assign in_start_y = s_tdata[2*CB-1:CB];
    assign in_end_x   = s_tdata[3*CB-1:2*CB];
    assign in_end_y   = s_tdata[4*CB-1:3*CB];
    assign in_color   = s_tdata[4*CB+31:4*CB];

    // accept only when idle and the output slot is free or draining now
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // span: longer axis of the two magnitudes
    logic [D_BITS-1:0]     ax_c, ay_c, span_c;

    assign ax_c   = dx_reg[D_BITS-1] ? (~dx_reg + 1'b1) : dx_reg;
    assign ay_c   = dy_reg[D_BITS-1] ? (~dy_reg + 1'b1) : dy_reg;
    assign span_c = (ax_c >= ay_c) ? ax_c : ay_c;

    // shared divider: x in SPAN, y on x done
    dda_pkg::dda_div_stat_t div_stat;
    logic                  div_start;
    logic [D_BITS-1:0]     div_num, div_den;
    logic [Q_BITS-1:0]     div_quo;
    logic [STEP_BITS-1:0]  quo_ext, quo_neg;

    assign div_start = (state_reg == ST_SPAN) || ((state_reg == ST_DIV_X) && div_stat.done);
    assign div_num   = (state_reg == ST_SPAN) ? ax_c : ay_reg;
    assign div_den   = (state_reg == ST_SPAN) ? span_c : span_reg;

    dda_div #(
        .NUM_BITS (D_BITS),
        .Q_BITS   (Q_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign quo_ext = {1'b0, div_quo};
    assign quo_neg = ~quo_ext + 1'b1;

    // pixel rounding: half away from zero is (p + half - neg) >>> FB
    logic [POS_BITS-1:0]   rnd_x, rnd_y;
    logic [CB-1:0]         px_c, py_c;
    logic                  vis_c;

    assign rnd_x = pos_x_reg + (pos_x_reg[POS_BITS-1] ? (HALF - 1'b1) : HALF);
    assign rnd_y = pos_y_reg + (pos_y_reg[POS_BITS-1] ? (HALF - 1'b1) : HALF);
    assign px_c  = rnd_x[FB+CB-1:FB];
    assign py_c  = rnd_y[FB+CB-1:FB];
    assign vis_c = !px_c[CB-1] && !py_c[CB-1]
                   && (VIS_BITS'(px_c) < VIS_BITS'(width_reg))
                   && (VIS_BITS'(py_c) < VIS_BITS'(height_reg));

    always_comb
    begin
        state_next       = state_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        ay_next          = ay_reg;
        span_next        = span_reg;
        span_zero_next   = span_zero_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        pixels_left_next = pixels_left_reg;
        color_next       = color_reg;
        line_active_next = line_active_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_color_next   = out_color_reg;
        out_vis_next     = out_vis_reg;
        out_last_next    = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dda_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_data;
                dda_pkg::REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == dda_pkg::KIND_START))
                begin
                    dx_next    = {in_end_x[CB-1], in_end_x} - {in_start_x[CB-1], in_start_x};
                    dy_next    = {in_end_y[CB-1], in_end_y} - {in_start_y[CB-1], in_start_y};
                    pos_x_next = {in_start_x[CB-1], in_start_x, {FB{1'b0}}};
                    pos_y_next = {in_start_y[CB-1], in_start_y, {FB{1'b0}}};
                    color_next = in_color;
                    state_next = ST_SPAN;
                end
                else if (in_accept && line_active_reg)
                begin
                    // step beat: emit the current pixel, then advance
                    out_valid_next = 1'b1;
                    out_x_next     = px_c;
                    out_y_next     = py_c;
                    out_color_next = color_reg;
                    out_vis_next   = vis_c;
                    out_last_next  = (pixels_left_reg[D_BITS-1:1] == '0);
                    pos_x_next = pos_x_reg
                                 + {{(POS_BITS-STEP_BITS){step_x_reg[STEP_BITS-1]}}, step_x_reg};
                    pos_y_next = pos_y_reg
                                 + {{(POS_BITS-STEP_BITS){step_y_reg[STEP_BITS-1]}}, step_y_reg};
                    if (pixels_left_reg[D_BITS-1:1] == '0)
                    begin
                        pixels_left_next = '0;
                        line_active_next = 1'b0;
                    end
                    else
                    begin
                        pixels_left_next = pixels_left_reg - 1'b1;
                    end
                end
            end
            ST_SPAN:
            begin
                ay_next          = ay_c;
                span_next        = span_c;
                span_zero_next   = (span_c == '0);
                pixels_left_next = span_c + 1'b1;
                line_active_next = 1'b1;
                state_next       = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_stat.done)
                begin
                    if (span_zero_reg)
                        step_x_next = '0;
                    else
                        step_x_next = dx_reg[D_BITS-1] ? quo_neg : quo_ext;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_stat.done)
                begin
                    if (span_zero_reg)
                        step_y_next = '0;
                    else
                        step_y_next = dy_reg[D_BITS-1] ? quo_neg : quo_ext;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            pixels_left_reg <= '0;
            color_reg       <= '0;
            line_active_reg <= 1'b0;
            width_reg       <= '0;
            height_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            pixels_left_reg <= pixels_left_next;
            color_reg       <= color_next;
            line_active_reg <= line_active_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        ay_reg        <= ay_next;
        span_reg      <= span_next;
        span_zero_reg <= span_zero_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_vis_reg   <= out_vis_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // no input beat while the divider is working on a start
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !s_tready)
        else $error("input ready while divider busy");

    // an active line always has pixels to give
    a_active_left: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (pixels_left_reg != '0))
        else $error("active line with no pixels left");

    // the final pixel closes the line and is flagged last
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_tuser == dda_pkg::KIND_STEP) && line_active_reg
         && (pixels_left_reg == D_BITS'(1)))
        |=> (!line_active_reg && m_tvalid && m_tlast))
        else $error("last pixel did not close the line");

    // divider results arrive only while the sequencer waits for them
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y)))
        else $error("divider done outside a divide state");
`endif

endmodule

`default_nettype wire
